[rtl/hbs_pkg.sv]
// Package for the height burst segmenter: shared constants, request codes,
// configuration indexes and the controller/datapath command and status types.
// Depends on nothing.
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int HEIGHT_BITS_DEF  = 12;

    localparam int TIME_W     = 32;
    localparam int HEIGHT_W   = 12;
    localparam int LIMIT_W    = 7;
    localparam int DELAY_W    = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 48;

    localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RESET = 7'd64;
    localparam logic [DELAY_W-1:0] FINISH_DELAY_RESET = 8'd15;

    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINISH_DELAY = 1'b1;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_SUSPEND = 2'd2,
        REQ_RESUME  = 2'd3
    } req_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic zero;
    } hbs_cmd_t;

    typedef struct packed {
        logic finish;
        logic ovf;
        logic rd_last;
    } hbs_stat_t;

endpackage

[rtl/hbs_datapath.sv]
// Datapath of the height burst segmenter: configuration registers, profile
// state, sample memory and the drain read port.
// Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_datapath #(
    parameter int BUFFER_DEPTH = hbs_pkg::BUFFER_DEPTH_DEF,
    parameter int HEIGHT_BITS  = hbs_pkg::HEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hbs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  hbs_pkg::req_t                     req_type,
    input  logic [hbs_pkg::HEIGHT_W-1:0]      height,
    input  hbs_pkg::hbs_cmd_t                 cmd,
    output hbs_pkg::hbs_stat_t                stat,
    output logic [hbs_pkg::TIME_W-1:0]        time_offset,
    output logic [hbs_pkg::HEIGHT_W-1:0]      height_value
);
    import hbs_pkg::*;

    localparam int SW   = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int CW   = $clog2(BUFFER_DEPTH + 2);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW   = TIME_W + SW;

    logic [LIMIT_W-1:0] sample_limit_reg;
    logic [DELAY_W-1:0] finish_delay_reg;

    logic               open_reg, open_next;
    logic               armed_reg, armed_next;
    logic               paused_reg, paused_next;
    logic [DELAY_W-1:0] cd_reg, cd_next;
    logic [TIME_W-1:0]  rt_reg, rt_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      len_reg, len_next;
    logic [CW-1:0]      idx_reg, idx_next;

    logic [EW-1:0]      mem [BUFFER_DEPTH];
    logic [EW-1:0]      rd_reg;

    logic [SW-1:0]      h_in;
    logic               h_nz;
    logic               mem_we;
    logic               finish;

    assign h_in = height[SW-1:0];
    assign h_nz = (h_in != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_limit_reg <= SAMPLE_LIMIT_RESET;
            finish_delay_reg <= FINISH_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SAMPLE_LIMIT: sample_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_FINISH_DELAY: finish_delay_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        open_next   = open_reg;
        armed_next  = armed_reg;
        paused_next = paused_reg;
        cd_next     = cd_reg;
        rt_next     = rt_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        finish      = 1'b0;
        if (cmd.take)
        begin
            case (req_type)
                REQ_SAMPLE:
                begin
                    if (!paused_reg)
                    begin
                        if (h_nz)
                        begin
                            open_next  = 1'b1;
                            armed_next = 1'b0;
                            cd_next    = '0;
                            if (count_reg < CW'(BUFFER_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = CW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                count_next = CW'(BUFFER_DEPTH + 1);
                            end
                        end
                        else if (open_reg && !armed_reg)
                        begin
                            armed_next = 1'b1;
                            cd_next    = finish_delay_reg;
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (!paused_reg && open_reg)
                    begin
                        rt_next = rt_reg + 1'b1;
                        if (armed_reg)
                        begin
                            if (cd_reg <= DELAY_W'(1))
                            begin
                                finish     = 1'b1;
                                len_next   = count_reg;
                                idx_next   = '0;
                                open_next  = 1'b0;
                                armed_next = 1'b0;
                                cd_next    = '0;
                                rt_next    = '0;
                                count_next = '0;
                            end
                            else
                            begin
                                cd_next = cd_reg - 1'b1;
                            end
                        end
                    end
                end
                REQ_SUSPEND: paused_next = 1'b1;
                REQ_RESUME:  paused_next = 1'b0;
                default: ;
            endcase
        end
        if (cmd.rd)
        begin
            idx_next = CW'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            armed_reg  <= 1'b0;
            paused_reg <= 1'b0;
            cd_reg     <= '0;
            rt_reg     <= '0;
            count_reg  <= '0;
            len_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            armed_reg  <= armed_next;
            paused_reg <= paused_next;
            cd_reg     <= cd_next;
            rt_reg     <= rt_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= {rt_reg, h_in};
        end
        if (cmd.zero)
        begin
            rd_reg <= '0;
        end
        else if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    assign time_offset  = rd_reg[EW-1:SW];
    assign height_value = HEIGHT_W'(rd_reg[SW-1:0]);

    assign stat.finish  = finish;
    assign stat.ovf     = !((CMPW'(count_reg) <= CMPW'(sample_limit_reg)) &&
                            (count_reg <= CW'(BUFFER_DEPTH)));
    assign stat.rd_last = (CW'(idx_reg + 1'b1) == len_reg);

    a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (!open_reg && count_reg == '0 && rt_reg == '0))
        else $error("profile not closed after finish");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (idx_reg < len_reg))
        else $error("drain read beyond stored samples");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_DEPTH + 1))
        else $error("sample count beyond saturation value");

    a_no_take_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd || cmd.zero) |-> !cmd.take)
        else $error("input beat accepted while draining");

endmodule

[rtl/hbs_ctrl.sv]
// Controller of the height burst segmenter: accepts input beats while idle and
// sequences the drain of a finished profile or the overflow report.
// Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tlast,
    output logic               m_status,
    input  hbs_pkg::hbs_stat_t stat,
    output hbs_pkg::hbs_cmd_t  cmd
);
    import hbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_OVF
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   m_tlast_reg;
    logic   m_status_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.take = s_tvalid && (state_reg == ST_IDLE);
        cmd.rd   = (state_reg == ST_DRAIN) && out_free;
        cmd.zero = (state_reg == ST_OVF) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd || cmd.zero)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (stat.finish)
                    begin
                        state_reg <= stat.ovf ? ST_OVF : ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (out_free)
                    begin
                        m_tlast_reg  <= stat.rd_last;
                        m_status_reg <= 1'b0;
                        if (stat.rd_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OVF:
                begin
                    if (out_free)
                    begin
                        m_tlast_reg  <= 1'b1;
                        m_status_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_status = m_status_reg;

endmodule

[rtl/height_burst_segmenter.sv]
// Height burst segmenter: cuts a stream of height samples into item profiles.
// Input beats carry a request kind in s_tuser and a height in s_tdata. Samples,
// millisecond ticks, suspend and resume are each taken while s_tready is high.
// A closing tick (the end countdown running out) stops input for the drain:
// the controller enters its drain state, the first result beat is then
// registered from the memory read port, and while the receiver does not
// stall one stored sample leaves per cycle on the master side with tlast on
// the final one. Without stalls the drain rate is set by the single read
// port of the sample memory. An oversize profile gives one beat with tuser
// set, zero data and tlast. When the receiver stalls the drain waits with
// the pending beat held, and input stays blocked until the final beat of
// the profile has been loaded.
// Reset clears the profile state and loads the configuration defaults (limit
// 64, delay 15 ticks); the sample memory is not cleared. Configuration is
// written through cfg_we, cfg_addr and cfg_data while the block is idle.
// Depends on hbs_pkg, hbs_ctrl and hbs_datapath.
`timescale 1ns / 1ps

module height_burst_segmenter #(
    parameter int BUFFER_DEPTH = hbs_pkg::BUFFER_DEPTH_DEF,
    parameter int HEIGHT_BITS  = hbs_pkg::HEIGHT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hbs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hbs_pkg::S_DATA_W-1:0]    s_tdata,   // height[11:0], zero pad
    input  logic [1:0]                      s_tuser,   // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hbs_pkg::M_DATA_W-1:0]    m_tdata,   // time_offset[31:0],
                                                       // height_value[43:32], pad
    output logic                            m_tuser,   // status
    output logic                            m_tlast
);
    import hbs_pkg::*;

    hbs_cmd_t            cmd;
    hbs_stat_t           stat;
    logic [TIME_W-1:0]   time_offset;
    logic [HEIGHT_W-1:0] height_value;

    hbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_status (m_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    hbs_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .HEIGHT_BITS  (HEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .req_type     (req_t'(s_tuser)),
        .height       (s_tdata[HEIGHT_W-1:0]),
        .cmd          (cmd),
        .stat         (stat),
        .time_offset  (time_offset),
        .height_value (height_value)
    );

    assign m_tdata = M_DATA_W'({height_value, time_offset});

endmodule
